>>> rtl/brb_pkg.sv
package brb_pkg;

  // Fixed field widths of the channels
  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int OFF_W  = 10;
  localparam int LVL_W  = 11;

  // Defaults for the top level parameters
  localparam int DEPTH_DEF   = 1024;
  localparam int MAX_RUN_DEF = 64;
  localparam int CAP_RESET   = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_READ_CLIP = 2'd1,
    OP_READ_ALL  = 2'd2,
    OP_PEEK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_EMIT
  } state_t;

  // Operands of the shared modulo adder: (a + b) mod m, with a < m and b <= m
  typedef struct packed {
    logic [LVL_W-1:0] a;
    logic [LVL_W-1:0] b;
    logic [LVL_W-1:0] m;
  } modadd_req_t;

  // Clamp a raw capacity write into 1 .. depth
  function automatic logic [LVL_W-1:0] eff_cap(logic [LVL_W-1:0] raw, int unsigned depth);
    logic [LVL_W-1:0] c;
    c = raw;
    if (c == '0) c = LVL_W'(1);
    if (32'(c) > depth) c = LVL_W'(depth);
    return c;
  endfunction

endpackage

>>> rtl/brb_ifs.sv
interface brb_in_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [DATA_W-1:0] data_in;
  logic [CNT_W-1:0]  count;
  logic [OFF_W-1:0]  offset;

  modport source (output valid, operation, data_in, count, offset, input ready);
  modport sink   (input valid, operation, data_in, count, offset, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              byte_valid;
  logic              last;
  logic              accepted;
  logic [LVL_W-1:0]  level;

  modport source (output valid, data_out, byte_valid, last, accepted, level, input ready);
  modport sink   (input valid, data_out, byte_valid, last, accepted, level, output ready);
endinterface

interface brb_cfg_if;
  import brb_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = brb_pkg::DATA_W,
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/brb_modadd.sv
module brb_modadd (
  input  brb_pkg::modadd_req_t     req,
  output logic [brb_pkg::LVL_W-1:0] sum
);
  import brb_pkg::*;

  logic [LVL_W:0] raw;
  logic [LVL_W:0] mod_ext;

  // Add, then fold back once past the modulus
  always_comb begin
    raw     = {1'b0, req.a} + {1'b0, req.b};
    mod_ext = {1'b0, req.m};
    if (raw >= mod_ext) begin
      sum = LVL_W'(raw - mod_ext);
    end else begin
      sum = raw[LVL_W-1:0];
    end
  end

endmodule

>>> rtl/byte_ring_buffer_with_peek.sv
// Circular byte FIFO with clipped read, all-or-nothing read and peek.
// A write, refusal or empty run is settled in S_DECIDE and loaded into the output register
// once the output slot is free; the next item is taken only after the return to S_IDLE.
// A run of n bytes passes n times through S_FETCH and S_EMIT before the return to S_IDLE;
// each byte is read from the RAM in S_FETCH and emitted in S_EMIT, where the shared modulo adder advances the pointer.
// Reset (rst_n low, synchronous): head and level cleared, capacity 1024 (clamped to DEPTH).
module byte_ring_buffer_with_peek #(
  parameter int DEPTH   = brb_pkg::DEPTH_DEF,
  parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  brb_in_if.sink    in_ch,
  brb_out_if.source out_ch,
  brb_cfg_if.sink   cfg_ch
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(MAX_RUN + 1);

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [DATA_W-1:0] din_r;
  logic [RW-1:0]     cnt_r;
  logic [OFF_W-1:0]  off_r;

  logic [LVL_W-1:0]  cap_r;
  logic [LVL_W-1:0]  head_r, head_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [LVL_W-1:0]  ptr_r, ptr_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;

  logic              ov_r;
  logic [DATA_W-1:0] od_r;
  logic              obv_r, olast_r, oacc_r;
  logic [LVL_W-1:0]  olvl_r;

  logic              emit;
  logic [DATA_W-1:0] e_data;
  logic              e_bv, e_last, e_acc;
  logic [LVL_W-1:0]  e_lvl;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  modadd_req_t       ma_req;
  logic [LVL_W-1:0]  ma_sum;

  logic              in_acc, cfg_acc, slot_free;
  logic              is_read, full, rd_refuse, pk_refuse, dec_single, dec_acc;
  logic [LVL_W-1:0]  cnt_ext, clip_n;
  logic [LVL_W:0]    pk_end;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_acc   = cfg_ch.valid && cfg_ch.ready;
  assign slot_free = !ov_r || out_ch.ready;

  // Decision terms for the latched operation
  always_comb begin
    is_read   = (op_r == OP_READ_CLIP) || (op_r == OP_READ_ALL);
    full      = level_r >= cap_r;
    cnt_ext   = LVL_W'(cnt_r);
    clip_n    = (cnt_ext > level_r) ? level_r : cnt_ext;
    rd_refuse = (op_r == OP_READ_ALL) && (cnt_ext > level_r);
    pk_end    = (LVL_W + 1)'(off_r) + (LVL_W + 1)'(cnt_r);
    pk_refuse = pk_end > {1'b0, level_r};
    unique case (op_r)
      OP_WRITE: begin
        dec_single = 1'b1;
        dec_acc    = !full;
      end
      OP_READ_CLIP, OP_READ_ALL: begin
        dec_single = rd_refuse || (clip_n == '0);
        dec_acc    = !rd_refuse;
      end
      OP_PEEK: begin
        dec_single = pk_refuse || (cnt_r == '0);
        dec_acc    = !pk_refuse;
      end
      default: begin
        dec_single = 1'b1;
        dec_acc    = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!dec_single) begin
          state_nxt = S_FETCH;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = (rem_r == RW'(1)) ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    head_nxt  = head_r;
    level_nxt = level_r;
    ptr_nxt   = ptr_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    e_data    = '0;
    e_bv      = 1'b0;
    e_last    = 1'b0;
    e_acc     = 1'b0;
    e_lvl     = level_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(ma_sum);
    ram_re    = 1'b0;
    ram_raddr = AW'(ptr_r);
    ma_req.a  = ptr_r;
    ma_req.b  = LVL_W'(1);
    ma_req.m  = cap_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECIDE: begin
        // Route the operands for the append slot or the peek start
        if (op_r == OP_WRITE) begin
          ma_req.a = head_r;
          ma_req.b = level_r;
        end else if (op_r == OP_PEEK) begin
          ma_req.a = head_r;
          ma_req.b = LVL_W'(off_r);
        end
        if (dec_single) begin
          if (slot_free) begin
            emit   = 1'b1;
            e_last = 1'b1;
            e_acc  = dec_acc;
            if ((op_r == OP_WRITE) && !full) begin
              ram_we    = 1'b1;
              level_nxt = level_r + LVL_W'(1);
              e_lvl     = level_r + LVL_W'(1);
            end
          end
        end else begin
          ptr_nxt = is_read ? head_r : ma_sum;
          rem_nxt = is_read ? RW'(clip_n) : cnt_r;
        end
      end
      S_FETCH: begin
        ram_re = 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_data  = ram_rdata;
          e_bv    = 1'b1;
          e_last  = rem_r == RW'(1);
          e_acc   = 1'b1;
          ptr_nxt = ma_sum;
          rem_nxt = rem_r - RW'(1);
          if (is_read) begin
            level_nxt = level_r - LVL_W'(1);
            e_lvl     = level_r - LVL_W'(1);
            head_nxt  = (level_r == LVL_W'(1)) ? '0 : ma_sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  brb_modadd u_modadd (
    .req (ma_req),
    .sum (ma_sum)
  );

  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (din_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= eff_cap(LVL_W'(CAP_RESET), DEPTH);
      head_r  <= '0;
      level_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        cap_r   <= eff_cap(cfg_ch.capacity, DEPTH);
        head_r  <= '0;
        level_r <= '0;
      end else begin
        head_r  <= head_nxt;
        level_r <= level_nxt;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Latched operation, run counters and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.operation;
      din_r <= in_ch.data_in;
      off_r <= in_ch.offset;
      cnt_r <= (32'(in_ch.count) > MAX_RUN) ? RW'(MAX_RUN) : RW'(in_ch.count);
    end
    ptr_r <= ptr_nxt;
    rem_r <= rem_nxt;
    if (emit) begin
      od_r    <= e_data;
      obv_r   <= e_bv;
      olast_r <= e_last;
      oacc_r  <= e_acc;
      olvl_r  <= e_lvl;
    end
  end

  assign in_ch.ready       = state_r == S_IDLE;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = ov_r;
  assign out_ch.data_out   = od_r;
  assign out_ch.byte_valid = obv_r;
  assign out_ch.last       = olast_r;
  assign out_ch.accepted   = oacc_r;
  assign out_ch.level      = olvl_r;

`ifndef SYNTHESIS
  a_level_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= cap_r)
    else $error("fill level above capacity");

  a_head_lt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < cap_r)
    else $error("head index outside capacity");

  a_emit_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r != '0))
    else $error("byte emit with empty run counter");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_last) |=> (state_r == S_IDLE))
    else $error("sequencer not idle after final beat");
`endif

endmodule
